@@ rtl/core/hsvrgb_pkg.sv @@
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int CHAN_W = 8;
    localparam int PROD_W = 14;
    localparam int K_W    = 6;
    localparam int NUM_W  = 20;
    localparam int Y_W    = 24;
    localparam int Z_W    = 18;
    localparam int MUL_W  = 36;

    localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Reciprocal of 625 scaled by 2**27, rounded up; exact for all quotients needed here.
    localparam logic [Z_W-1:0] RECIP_625 = 18'd214749;
    localparam int RECIP_SHIFT = 27;

    typedef logic [2:0] sector_t;

    localparam sector_t SECT_RED_YELLOW    = 3'd0;
    localparam sector_t SECT_YELLOW_GREEN  = 3'd1;
    localparam sector_t SECT_GREEN_CYAN    = 3'd2;
    localparam sector_t SECT_CYAN_BLUE     = 3'd3;
    localparam sector_t SECT_BLUE_MAGENTA  = 3'd4;
    localparam sector_t SECT_MAGENTA_RED   = 3'd5;

    typedef struct packed {
        logic load_z;
        logic load_q;
    } scale_ctl_t;

endpackage

@@ rtl/core/hsvrgb_scale.sv @@
`timescale 1ns / 1ps

module hsvrgb_scale (
    input  logic                           clk,
    input  hsvrgb_pkg::scale_ctl_t         ctl,
    input  logic [hsvrgb_pkg::NUM_W-1:0]   num,
    output logic [hsvrgb_pkg::CHAN_W-1:0]  chan
);
    import hsvrgb_pkg::*;

    // The channel is floor(num * 255 / 600000) = floor(floor(num * 17 / 64) / 625).
    logic [Y_W-1:0]    y;
    logic [Z_W-1:0]    z_next;
    logic [Z_W-1:0]    z_reg;
    logic [MUL_W-1:0]  prod;
    logic [CHAN_W-1:0] q_next;
    logic [CHAN_W-1:0] q_reg;

    assign y      = ({{(Y_W-NUM_W){1'b0}}, num} << 4) + {{(Y_W-NUM_W){1'b0}}, num};
    assign z_next = y[Y_W-1:Y_W-Z_W];
    assign prod   = {{(MUL_W-Z_W){1'b0}}, z_reg} * {{(MUL_W-Z_W){1'b0}}, RECIP_625};
    assign q_next = prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];

    always_ff @(posedge clk)
    begin
        if (ctl.load_z)
        begin
            z_reg <= z_next;
        end
        if (ctl.load_q)
        begin
            q_reg <= q_next;
        end
    end

    assign chan = q_reg;

endmodule

@@ rtl/core/hsv_to_rgb_converter.sv @@
`timescale 1ns / 1ps

// HSV to RGB pixel converter.
// The input channel carries one pixel per transaction: hue_degrees (0 to 360),
// saturation_pct and value_pct (0 to 100), qualified by in_valid and in_ready.
// The output channel carries red, green, blue and range_error per transaction,
// qualified by out_valid and out_ready. Any input out of range yields black with
// range_error set.
// A pixel passes from its input transaction to the output through five
// register stages: the range check and s*v product, the chroma and offset
// products, the scaling by 17/64, the reciprocal multiply by 1/625 and the
// channel selection. One pixel is accepted per clock cycle while out_ready is high.
// When the receiver stalls, the pipeline holds its contents and keeps accepting
// transactions until every stage is occupied; in_ready then falls, and nothing is
// lost or repeated.
// Reset empties the pipeline: out_valid goes low and in_ready is high afterwards.
module hsv_to_rgb_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]    hue_degrees,
    input  logic [hsvrgb_pkg::PCT_W-1:0]    saturation_pct,
    input  logic [hsvrgb_pkg::PCT_W-1:0]    value_pct,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hsvrgb_pkg::CHAN_W-1:0]   red,
    output logic [hsvrgb_pkg::CHAN_W-1:0]   green,
    output logic [hsvrgb_pkg::CHAN_W-1:0]   blue,
    output logic                            range_error
);
    import hsvrgb_pkg::*;

    logic valid1_reg, valid2_reg, valid3_reg, valid4_reg, valid5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic              err1_next, err1_reg, err2_reg, err3_reg, err4_reg;
    sector_t           sector1_next, sector1_reg, sector2_reg, sector3_reg, sector4_reg;
    logic [HUE_W-1:0]  base_deg;
    logic [HUE_W-1:0]  k_full;
    logic [K_W-1:0]    k1_reg;
    logic [PROD_W-1:0] p1_next, p1_reg;
    logic [PCT_W-1:0]  val1_reg;

    logic [PROD_W-1:0] diff2;
    logic [NUM_W-1:0]  mn2_next, mn2_reg;
    logic [NUM_W-1:0]  xn2_next, xn2_reg;
    logic [NUM_W-1:0]  a2_next, a2_reg;
    logic [NUM_W-1:0]  bx2;

    scale_ctl_t        scale_ctl;
    logic [CHAN_W-1:0] qa, qb, qm;

    logic [CHAN_W-1:0] red_next, green_next, blue_next;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;
    logic              err5_reg;

    assign rdy5     = !valid5_reg || out_ready;
    assign rdy4     = !valid4_reg || rdy5;
    assign rdy3     = !valid3_reg || rdy4;
    assign rdy2     = !valid2_reg || rdy3;
    assign rdy1     = !valid1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                valid1_reg <= in_valid;
            end
            if (rdy2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (rdy3)
            begin
                valid3_reg <= valid2_reg;
            end
            if (rdy4)
            begin
                valid4_reg <= valid3_reg;
            end
            if (rdy5)
            begin
                valid5_reg <= valid4_reg;
            end
        end
    end

    // Stage 1: range check, sector, distance into the sector and the s*v product.
    assign err1_next = (hue_degrees > HUE_MAX) || (saturation_pct > PCT_MAX)
                       || (value_pct > PCT_MAX);

    always_comb
    begin
        case (hue_degrees) inside
            [9'd0:9'd59]:    sector1_next = SECT_RED_YELLOW;
            [9'd60:9'd119]:  sector1_next = SECT_YELLOW_GREEN;
            [9'd120:9'd179]: sector1_next = SECT_GREEN_CYAN;
            [9'd180:9'd239]: sector1_next = SECT_CYAN_BLUE;
            [9'd240:9'd299]: sector1_next = SECT_BLUE_MAGENTA;
            default:         sector1_next = SECT_MAGENTA_RED;
        endcase
    end

    assign base_deg = {{(HUE_W-3){1'b0}}, sector1_next} * 9'd60;
    assign k_full   = sector1_next[0] ? (base_deg + 9'd60 - hue_degrees)
                                      : (hue_degrees - base_deg);
    assign p1_next  = {{(PROD_W-PCT_W){1'b0}}, saturation_pct}
                      * {{(PROD_W-PCT_W){1'b0}}, value_pct};

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            err1_reg    <= err1_next;
            sector1_reg <= sector1_next;
            k1_reg      <= k_full[K_W-1:0];
            p1_reg      <= p1_next;
            val1_reg    <= value_pct;
        end
    end

    // Stage 2: numerators over 600000 for the offset m, for X and for C + m.
    assign diff2    = {{(PROD_W-PCT_W){1'b0}}, val1_reg} * 14'd100 - p1_reg;
    assign mn2_next = {{(NUM_W-PROD_W){1'b0}}, diff2} * 20'd60;
    assign xn2_next = {{(NUM_W-K_W){1'b0}}, k1_reg} * {{(NUM_W-PROD_W){1'b0}}, p1_reg};
    assign a2_next  = {{(NUM_W-PCT_W){1'b0}}, val1_reg} * 20'd6000;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            err2_reg    <= err1_reg;
            sector2_reg <= sector1_reg;
            mn2_reg     <= mn2_next;
            xn2_reg     <= xn2_next;
            a2_reg      <= a2_next;
        end
    end

    // Stages 3 and 4: scaling of the three distinct channel levels.
    assign bx2              = xn2_reg + mn2_reg;
    assign scale_ctl.load_z = rdy3;
    assign scale_ctl.load_q = rdy4;

    hsvrgb_scale u_scale_a (
        .clk  (clk),
        .ctl  (scale_ctl),
        .num  (a2_reg),
        .chan (qa)
    );

    hsvrgb_scale u_scale_b (
        .clk  (clk),
        .ctl  (scale_ctl),
        .num  (bx2),
        .chan (qb)
    );

    hsvrgb_scale u_scale_m (
        .clk  (clk),
        .ctl  (scale_ctl),
        .num  (mn2_reg),
        .chan (qm)
    );

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            err3_reg    <= err2_reg;
            sector3_reg <= sector2_reg;
        end
        if (rdy4)
        begin
            err4_reg    <= err3_reg;
            sector4_reg <= sector3_reg;
        end
    end

    // Stage 5: place the levels in the channels by sector.
    always_comb
    begin
        case (sector4_reg)
            SECT_RED_YELLOW:
            begin
                red_next = qa; green_next = qb; blue_next = qm;
            end
            SECT_YELLOW_GREEN:
            begin
                red_next = qb; green_next = qa; blue_next = qm;
            end
            SECT_GREEN_CYAN:
            begin
                red_next = qm; green_next = qa; blue_next = qb;
            end
            SECT_CYAN_BLUE:
            begin
                red_next = qm; green_next = qb; blue_next = qa;
            end
            SECT_BLUE_MAGENTA:
            begin
                red_next = qb; green_next = qm; blue_next = qa;
            end
            default:
            begin
                red_next = qa; green_next = qm; blue_next = qb;
            end
        endcase
        if (err4_reg)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            err5_reg  <= err4_reg;
        end
    end

    assign out_valid   = valid5_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign range_error = err5_reg;

endmodule

@@ test/hsv_to_rgb_converter_test.sv @@
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;

    import hsvrgb_pkg::*;

    localparam longint unsigned SECTOR_DEG   = 60;
    localparam longint unsigned FULL_SCALE   = 255;
    localparam longint unsigned COMMON_DENOM = 600000;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int TABLE_ROWS = 24;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              range_error;
    } pixel_rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
        logic             known;
        pixel_rgb_t       rgb;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [HUE_W-1:0]    hue_degrees = '0;
    logic [PCT_W-1:0]    saturation_pct = '0;
    logic [PCT_W-1:0]    value_pct = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic                range_error;

    pixel_rgb_t offered_rgb = '0;
    pixel_rgb_t pending_pixels[$];
    int         mismatch_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_left = 0;
    bit         hold_request = 1'b0;

    stim_row_t pixel_table [0:TABLE_ROWS-1] = '{
        '{9'd0,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
        '{9'd0,   7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
        '{9'd120, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
        '{9'd240, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
        '{9'd360, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
        '{9'd0,   7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{9'd361, 7'd50,  7'd50,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{9'd511, 7'd127, 7'd127, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{9'd0,   7'd101, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{9'd0,   7'd0,   7'd101, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{9'd360, 7'd100, 7'd101, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{9'd100, 7'd127, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{9'd60,  7'd100, 7'd100, 1'b0, '0},
        '{9'd180, 7'd100, 7'd100, 1'b0, '0},
        '{9'd300, 7'd100, 7'd100, 1'b0, '0},
        '{9'd59,  7'd100, 7'd100, 1'b0, '0},
        '{9'd61,  7'd75,  7'd80,  1'b0, '0},
        '{9'd119, 7'd33,  7'd67,  1'b0, '0},
        '{9'd359, 7'd100, 7'd100, 1'b0, '0},
        '{9'd300, 7'd1,   7'd1,   1'b0, '0},
        '{9'd30,  7'd50,  7'd50,  1'b0, '0},
        '{9'd210, 7'd100, 7'd50,  1'b0, '0},
        '{9'd270, 7'd99,  7'd99,  1'b0, '0},
        '{9'd330, 7'd20,  7'd100, 1'b0, '0}
    };

    hsv_to_rgb_converter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .hue_degrees    (hue_degrees),
        .saturation_pct (saturation_pct),
        .value_pct      (value_pct),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .range_error    (range_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CHAN_W-1:0] scale_channel(input longint unsigned num);
        longint unsigned q;
        q = (num * FULL_SCALE) / COMMON_DENOM;
        return (q > FULL_SCALE) ? CHAN_W'(FULL_SCALE) : CHAN_W'(q);
    endfunction

    function automatic pixel_rgb_t convert_hsv(input logic [HUE_W-1:0] h,
                                               input logic [PCT_W-1:0] s,
                                               input logic [PCT_W-1:0] v);
        longint unsigned hh, ss, vv, chroma, xn, mn, t, k, rn, gn, bn;
        sector_t    sector;
        pixel_rgb_t px;
        if (h > HUE_MAX || s > PCT_MAX || v > PCT_MAX)
        begin
            px = '{CHAN_W'(0), CHAN_W'(0), CHAN_W'(0), 1'b1};
            return px;
        end
        hh = h;
        ss = s;
        vv = v;
        chroma = SECTOR_DEG * ss * vv;
        t = hh % (2 * SECTOR_DEG);
        k = (t >= SECTOR_DEG) ? (2 * SECTOR_DEG - t) : t;
        xn = ss * vv * k;
        mn = SECTOR_DEG * (longint'(PCT_MAX) * vv - ss * vv);
        sector = (hh / SECTOR_DEG > 5) ? SECT_MAGENTA_RED : sector_t'(hh / SECTOR_DEG);
        case (sector)
            SECT_RED_YELLOW:   begin rn = chroma; gn = xn;     bn = 0;      end
            SECT_YELLOW_GREEN: begin rn = xn;     gn = chroma; bn = 0;      end
            SECT_GREEN_CYAN:   begin rn = 0;      gn = chroma; bn = xn;     end
            SECT_CYAN_BLUE:    begin rn = 0;      gn = xn;     bn = chroma; end
            SECT_BLUE_MAGENTA: begin rn = xn;     gn = 0;      bn = chroma; end
            default:           begin rn = chroma; gn = 0;      bn = xn;     end
        endcase
        px = '{scale_channel(rn + mn), scale_channel(gn + mn), scale_channel(bn + mn), 1'b0};
        return px;
    endfunction

    task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [PCT_W-1:0] s,
                              input logic [PCT_W-1:0] v, input pixel_rgb_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        hue_degrees    <= h;
        saturation_pct <= s;
        value_pct      <= v;
        offered_rgb    <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic offer_random_pixel();
        logic [HUE_W-1:0] h;
        logic [PCT_W-1:0] s;
        logic [PCT_W-1:0] v;
        int               pick;
        pick = $urandom_range(0, 19);
        if (pick < 15)
        begin
            h = HUE_W'($urandom_range(0, 360));
            s = PCT_W'($urandom_range(0, 100));
            v = PCT_W'($urandom_range(0, 100));
        end
        else if (pick < 17)
        begin
            h = HUE_W'(SECTOR_DEG * $urandom_range(0, 6) + $urandom_range(0, 1));
            s = $urandom_range(0, 1) ? PCT_MAX : PCT_W'($urandom_range(0, 100));
            v = $urandom_range(0, 1) ? PCT_MAX : PCT_W'($urandom_range(0, 1));
        end
        else
        begin
            h = HUE_W'($urandom_range(0, 511));
            s = PCT_W'($urandom_range(0, 127));
            v = PCT_W'($urandom_range(0, 127));
        end
        send_pixel(h, s, v, convert_hsv(h, s, v));
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_failure(input string what, input pixel_rgb_t want,
                                input pixel_rgb_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected r=%0d g=%0d b=%0d err=%0d, got r=%0d g=%0d b=%0d err=%0d",
                     what, want.red, want.green, want.blue, want.range_error,
                     got.red, got.green, got.blue, got.range_error);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        pixel_rgb_t want;
        pixel_rgb_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_pixels.push_back(offered_rgb);
            if (out_valid && out_ready)
            begin
                got = '{red, green, blue, range_error};
                if (pending_pixels.size() == 0)
                    note_failure("unexpected transaction", '0, got);
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.range_error !== want.range_error)
                        note_failure("mismatch", want, got);
                end
            end
        end
    end

    initial
    begin
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 48;
        for (i = 0; i < TABLE_ROWS; i++)
            send_pixel(pixel_table[i].hue, pixel_table[i].sat, pixel_table[i].val,
                       pixel_table[i].known ? pixel_table[i].rgb :
                       convert_hsv(pixel_table[i].hue, pixel_table[i].sat, pixel_table[i].val));
        wait_for_drain();
        repeat (360) offer_random_pixel();

        send_idle_pct = 0;
        hold_request = 1'b1;
        repeat (25) offer_random_pixel();

        send_idle_pct = 48;
        recv_idle_pct = 27;
        repeat (370) offer_random_pixel();
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (370) offer_random_pixel();

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_scale.sv
rtl/core/hsv_to_rgb_converter.sv
test/hsv_to_rgb_converter_test.sv
